[design/plwcm_pkg.sv]
`default_nettype none

package plwcm_pkg;

  localparam int POS_W   = 16;
  localparam int COLOR_W = 32;
  localparam int CH_W    = 8;
  // 2*num + d of the blend, and the doubled segment length
  localparam int NUM_W   = 25;
  localparam int DEN_W   = 17;
  localparam int QUO_W   = 8;

  localparam logic [POS_W-1:0] FULL_SCALE = 16'hFFFF;

  typedef enum logic [1:0] {
    FUNC_CLEAR    = 2'd0,
    FUNC_APPEND   = 2'd1,
    FUNC_CLASSIFY = 2'd2,
    FUNC_NONE     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_ORDER = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[design/piecewise_linear_color_map_unit.sv]
`default_nettype none

// Piecewise-linear RGBA colour map.
// Input stream s_*: s_tuser carries the command (clear list, append point,
// classify sample); s_tdata carries the point position and colour and the
// sample. Output stream m_*: one transfer per input transfer, colour in
// m_tdata and append status in m_tuser.
// Clear, append and unused commands go from idle to the done state and back. A
// classify walks the stored points through the point memory, a read state and
// a compare state per point read (the memory read is registered ahead of the
// compare), then runs each of the four channels through one shared restoring
// divider: a multiply state that starts it, then a divide state that waits for
// its quotient. Each point below the sample is read, and the one that ends the
// search; a zero-length segment skips the divider.
// Only one item is in work at a time; s_tready is high in the idle state.
// The result sits in an output register, so a new item is taken while it
// waits; a finished item then holds until m_tready frees the register.
// Reset empties the point list; point memory contents are not cleared.
module piecewise_linear_color_map_unit #(
  parameter int MAX_POINTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // key_position[15:0], key_red[23:16], key_green[31:24], key_blue[39:32],
  // key_alpha[47:40], sample[55:48]
  input  wire logic [55:0] s_tdata,
  // func[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic [31:0]      m_tdata,
  // status[1:0]
  output logic [1:0]       m_tuser
);
  import plwcm_pkg::*;

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int ENT_W  = COLOR_W + POS_W;

  state_t state, state_next;

  logic [ENT_W-1:0] mem [MAX_POINTS];
  logic [ENT_W-1:0] rd_data;
  logic             wr_en;

  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [CNT_W-1:0]   n, n_next;
  logic [POS_W-1:0]   last_pos, last_pos_next;
  logic [POS_W-1:0]   sample_pos, sample_pos_next;
  logic [POS_W-1:0]   p0, p0_next, p1, p1_next;
  logic [COLOR_W-1:0] c0, c0_next, c1, c1_next;
  logic [1:0]         ch, ch_next;
  logic [COLOR_W-1:0] res_color, res_color_next;
  logic [1:0]         res_status, res_status_next;
  logic               out_load;

  func_t            func;
  logic [POS_W-1:0] in_pos;
  logic [POS_W-1:0] rd_pos;

  logic [POS_W-1:0] seg_len, seg_off, seg_off_c;
  logic [CH_W-1:0]  ch_a, ch_b;
  logic [NUM_W-2:0] blend_sum;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_start, div_done;
  logic [QUO_W-1:0] div_quo;

  assign func   = func_t'(s_tuser);
  assign in_pos = s_tdata[15:0];
  assign rd_pos = rd_data[POS_W-1:0];

  // blend numerator for the current channel
  always_comb begin
    seg_len   = p1 - p0;
    seg_off   = sample_pos - p0;
    seg_off_c = (seg_off > seg_len) ? seg_len : seg_off;
    ch_a      = c0[{ch, 3'b000} +: CH_W];
    ch_b      = c1[{ch, 3'b000} +: CH_W];
    blend_sum = (NUM_W-1)'(ch_a) * (NUM_W-1)'(seg_len - seg_off_c)
              + (NUM_W-1)'(ch_b) * (NUM_W-1)'(seg_off_c);
    div_num   = {blend_sum, 1'b0} + NUM_W'(seg_len);
    div_den   = {seg_len, 1'b0};
  end

  plwcm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt[ADDR_W-1:0]] <= {s_tdata[47:16], in_pos};
    end
    rd_data <= mem[n[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    n          <= n_next;
    last_pos   <= last_pos_next;
    sample_pos <= sample_pos_next;
    p0         <= p0_next;
    p1         <= p1_next;
    c0         <= c0_next;
    c1         <= c1_next;
    ch         <= ch_next;
    res_color  <= res_color_next;
    res_status <= res_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= res_color;
      m_tuser <= res_status;
    end
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    n_next          = n;
    last_pos_next   = last_pos;
    sample_pos_next = sample_pos;
    p0_next         = p0;
    p1_next         = p1;
    c0_next         = c0;
    c1_next         = c1;
    ch_next         = ch;
    res_color_next  = res_color;
    res_status_next = res_status;
    wr_en           = 1'b0;
    div_start       = 1'b0;
    out_load        = 1'b0;
    s_tready        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          res_color_next  = '0;
          res_status_next = STATUS_OK;
          state_next      = ST_DONE;
          unique case (func)
            FUNC_CLEAR: begin
              cnt_next = '0;
            end
            FUNC_APPEND: begin
              if (cnt >= CNT_W'(MAX_POINTS)) begin
                res_status_next = STATUS_FULL;
              end else if (cnt != '0 && in_pos < last_pos) begin
                res_status_next = STATUS_ORDER;
              end else begin
                wr_en         = 1'b1;
                cnt_next      = cnt + 1'b1;
                last_pos_next = in_pos;
              end
            end
            FUNC_CLASSIFY: begin
              sample_pos_next = {s_tdata[55:48], s_tdata[55:48]};
              p0_next         = '0;
              c0_next         = '0;
              n_next          = '0;
              ch_next         = '0;
              if (cnt == '0) begin
                p1_next    = FULL_SCALE;
                c1_next    = '0;
                state_next = ST_MUL;
              end else begin
                state_next = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (sample_pos > rd_pos) begin
          p0_next = rd_pos;
          c0_next = rd_data[ENT_W-1:POS_W];
          n_next  = n + 1'b1;
          if (n + 1'b1 < cnt) begin
            state_next = ST_READ;
          end else begin
            p1_next    = FULL_SCALE;
            c1_next    = '0;
            state_next = ST_MUL;
          end
        end else begin
          p1_next    = rd_pos;
          c1_next    = rd_data[ENT_W-1:POS_W];
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        // zero-length segment keeps the earlier colour
        if (p1 <= p0) begin
          res_color_next = c0;
          state_next     = ST_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_color_next[{ch, 3'b000} +: CH_W] = div_quo;
          if (ch == 2'd3) begin
            state_next = ST_DONE;
          end else begin
            ch_next    = ch + 1'b1;
            state_next = ST_MUL;
          end
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/plwcm_div.sv]
`default_nettype none

module plwcm_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [plwcm_pkg::NUM_W-1:0] num,
  input  wire logic [plwcm_pkg::DEN_W-1:0] den,
  output logic done,
  output logic [plwcm_pkg::QUO_W-1:0] quo
);
  import plwcm_pkg::*;

  localparam int STEP_W = $clog2(QUO_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsh;

  // restoring division, one quotient bit a cycle, msb first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= NUM_W'({den, {(QUO_W-1){1'b0}}});
      quo <= '0;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

endmodule

`default_nettype wire

[sim/piecewise_linear_color_map_unit_tb.sv]
`timescale 1ns / 100ps

module piecewise_linear_color_map_unit_tb;
  import plwcm_pkg::*;

  localparam int NUM_POINTS = 16;

  typedef struct {
    logic [31:0] rgba;
    status_t     status;
  } color_result_t;

  // mirrors the point list and predicts one colour result per input transfer
  class color_map_scoreboard;
    logic [15:0]   key_pos[NUM_POINTS];
    logic [31:0]   key_rgba[NUM_POINTS];
    int unsigned   key_count;
    color_result_t pending[$];
    int            errors;

    function new();
      key_count = 0;
      errors = 0;
    endfunction

    function logic [7:0] blend_channel(logic [7:0] a, logic [7:0] b, int unsigned t,
                                       int unsigned d);
      int unsigned num;
      if (d == 0) return a;
      if (t > d) t = d;
      num = a * (d - t) + b * t;
      return 8'((2 * num + d) / (2 * d));
    endfunction

    function void note_input(func_t f, logic [55:0] d);
      color_result_t exp_res;
      int unsigned p, p0, p1, n;
      logic [31:0] c0, c1;
      exp_res.rgba = '0;
      exp_res.status = STATUS_OK;
      case (f)
        FUNC_CLEAR: begin
          key_count = 0;
        end
        FUNC_APPEND: begin
          if (key_count >= NUM_POINTS) begin
            exp_res.status = STATUS_FULL;
          end else if (key_count > 0 && d[15:0] < key_pos[key_count-1]) begin
            exp_res.status = STATUS_ORDER;
          end else begin
            key_pos[key_count] = d[15:0];
            key_rgba[key_count] = d[47:16];
            key_count++;
          end
        end
        FUNC_CLASSIFY: begin
          p = d[55:48];
          p = p * 257;
          p0 = 0;
          c0 = '0;
          n = 0;
          // skip every point strictly below the sample position
          while (n < key_count && p > key_pos[n]) begin
            p0 = key_pos[n];
            c0 = key_rgba[n];
            n++;
          end
          if (n < key_count) begin
            p1 = key_pos[n];
            c1 = key_rgba[n];
          end else begin
            p1 = 65535;
            c1 = '0;
          end
          for (int ch = 0; ch < 4; ch++) begin
            if (p1 > p0)
              exp_res.rgba[8*ch +: 8] = blend_channel(c0[8*ch +: 8], c1[8*ch +: 8],
                                                      p - p0, p1 - p0);
            else
              exp_res.rgba[8*ch +: 8] = c0[8*ch +: 8];
          end
        end
        default: ;
      endcase
      pending.insert(pending.size(), exp_res);
    endfunction

    function void check_result(logic [31:0] rgba, logic [1:0] status);
      color_result_t exp_res;
      string ch_name[4];
      ch_name = '{"red", "green", "blue", "alpha"};
      if (pending.size() == 0) begin
        $display("%0t: unexpected result rgba=%h status=%0d", $time, rgba, status);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      for (int ch = 0; ch < 4; ch++) begin
        if (rgba[8*ch +: 8] !== exp_res.rgba[8*ch +: 8]) begin
          $display("%0t: %s mismatch expected %0d actual %0d", $time, ch_name[ch],
                   exp_res.rgba[8*ch +: 8], rgba[8*ch +: 8]);
          errors++;
        end
      end
      if (status !== exp_res.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time,
                 exp_res.status, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  color_map_scoreboard sb = new();
  bit          quiet = 1'b0;
  int          items_sent = 0;
  int          stall_left = 0;

  piecewise_linear_color_map_unit #(
    .MAX_POINTS(NUM_POINTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure in short bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= (stall_left == 1);
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready)
      sb.check_result(m_tdata, m_tuser);
  end

  // valid stays high on return so back-to-back transfers need no toggle
  task automatic send_item(input func_t f, input logic [15:0] pos, input logic [31:0] rgba,
                           input logic [7:0] smp);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= {smp, rgba, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(f, {smp, rgba, pos});
    items_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic run_sequence();
    int unsigned n_keys, n_samples, prev, p, s;
    int unsigned keys[$];
    n_keys = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 6);
    n_samples = $urandom_range(1, 8);
    prev = 0;
    if ($urandom_range(0, 9) != 0)
      send_item(FUNC_CLEAR, 16'($urandom), $urandom, 8'($urandom));
    for (int i = 0; i < n_keys; i++) begin
      case ($urandom_range(0, 7))
        0: p = prev;
        1: p = (prev > 0) ? $urandom_range(0, prev - 1) : 0;
        2: begin
          s = (prev + 256) / 257;
          if (s > 255) s = 255;
          p = 257 * $urandom_range(s, 255);
        end
        3: p = 65535;
        default: begin
          p = prev + $urandom_range(0, 12000);
          if (p > 65535) p = 65535;
        end
      endcase
      if (p > prev) prev = p;
      keys.insert(keys.size(), p);
      send_item(FUNC_APPEND, 16'(p), $urandom, 8'($urandom));
    end
    for (int i = 0; i < n_samples; i++) begin
      if (keys.size() > 0 && $urandom_range(0, 1) == 0) begin
        // land on or just beside a stored point
        s = keys[$urandom_range(0, keys.size() - 1)] / 257 + $urandom_range(0, 2);
        s = (s == 0) ? 0 : s - 1;
        if (s > 255) s = 255;
      end else begin
        s = $urandom_range(0, 255);
      end
      send_item(FUNC_CLASSIFY, 16'($urandom), $urandom, 8'(s));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty list and unused code
    send_item(FUNC_CLASSIFY, 16'h0000, 32'h0, 8'd0);
    send_item(FUNC_CLASSIFY, 16'hffff, 32'hffffffff, 8'd255);
    send_item(FUNC_NONE, 16'hffff, 32'hffffffff, 8'hff);
    // point at zero with sample zero gives black
    send_item(FUNC_APPEND, 16'h0000, 32'hffffffff, 8'h00);
    send_item(FUNC_CLASSIFY, 16'h0000, 32'h0, 8'd0);
    send_item(FUNC_CLASSIFY, 16'h0000, 32'h0, 8'd1);
    // equal position accepted, lower position refused
    send_item(FUNC_APPEND, 16'h8080, 32'h80402010, 8'h00);
    send_item(FUNC_APPEND, 16'h8080, 32'h01fe7f00, 8'h00);
    send_item(FUNC_APPEND, 16'h1000, 32'h55aa55aa, 8'h00);
    send_item(FUNC_CLASSIFY, 16'h0000, 32'h0, 8'd128);
    send_item(FUNC_CLASSIFY, 16'h0000, 32'h0, 8'd129);
    send_item(FUNC_CLASSIFY, 16'h0000, 32'h0, 8'd255);
    send_item(FUNC_APPEND, 16'hffff, 32'hc0ffee11, 8'h00);
    send_item(FUNC_CLASSIFY, 16'h0000, 32'h0, 8'd255);
    send_item(FUNC_CLASSIFY, 16'h0000, 32'h0, 8'd254);
    send_item(FUNC_CLEAR, 16'hffff, 32'hffffffff, 8'hff);
    // fill the list, then full takes precedence over order
    for (int i = 0; i < NUM_POINTS; i++)
      send_item(FUNC_APPEND, 16'(i * 16'h1000 + 16'h0fff), $urandom, 8'h00);
    send_item(FUNC_APPEND, 16'h0000, 32'h12345678, 8'h00);
    send_item(FUNC_APPEND, 16'hffff, 32'h12345678, 8'h00);
    send_item(FUNC_CLASSIFY, 16'h0000, 32'h0, 8'd255);
    send_item(FUNC_CLASSIFY, 16'h0000, 32'h0, 8'd0);

    drain_results();

    while (items_sent < 420) begin
      if (items_sent > 360) quiet = 1'b1;
      if ($urandom_range(0, 9) < 8)
        run_sequence();
      else
        send_item(func_t'($urandom_range(0, 3)), 16'($urandom), $urandom, 8'($urandom));
    end

    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("piecewise_linear_color_map_unit_tb OK");
    else
      $display("piecewise_linear_color_map_unit_tb NOT OK");
    $finish;
  end

  initial begin
    #5000000;
    $display("piecewise_linear_color_map_unit_tb NOT OK");
    $finish;
  end

endmodule

[filelist.f]
design/plwcm_pkg.sv
design/plwcm_div.sv
design/piecewise_linear_color_map_unit.sv
sim/piecewise_linear_color_map_unit_tb.sv
